>>> hw/rtl/brl_pkg.sv
package brl_pkg;

  localparam int unsigned ColorBits   = 8;
  localparam int unsigned ApbDataBits = 32;
  localparam int unsigned ApbAddrBits = 3;

  localparam logic [ColorBits-1:0] ColorReset = 8'd1;

  // Register word index, taken from paddr[2].
  localparam logic RegPixelColor = 1'b0;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_PIXEL = 1'b1
  } cmd_e;

  // y grows downward as given; "rise" means y grows along the line.
  typedef enum logic [2:0] {
    OCT_HORIZ      = 3'd0,
    OCT_VERT       = 3'd1,
    OCT_DIAG_RISE  = 3'd2,
    OCT_DIAG_FALL  = 3'd3,
    OCT_SHAL_RISE  = 3'd4,
    OCT_STEEP_RISE = 3'd5,
    OCT_SHAL_FALL  = 3'd6,
    OCT_STEEP_FALL = 3'd7
  } octant_e;

  typedef struct packed {
    logic last;
  } step_flags_t;

endpackage

>>> hw/rtl/brl_setup.sv
module brl_setup #(
  parameter int unsigned CoordBits = 10
) (
  input  logic [CoordBits-1:0]   x_a_i,
  input  logic [CoordBits-1:0]   y_a_i,
  input  logic [CoordBits-1:0]   x_b_i,
  input  logic [CoordBits-1:0]   y_b_i,
  output logic [CoordBits-1:0]   cur_x_o,
  output logic [CoordBits-1:0]   cur_y_o,
  output logic [CoordBits-1:0]   stop_o,
  output logic [CoordBits+2:0]   err_o,
  output logic [CoordBits+2:0]   inc_no_step_o,
  output logic [CoordBits+2:0]   inc_step_o,
  output brl_pkg::octant_e       mode_o
);

  localparam int unsigned ErrBits = CoordBits + 3;

  logic                      swap;
  logic [CoordBits-1:0]      x0, y0, x1, y1;
  logic signed [ErrBits-1:0] dx, dy, ndx, ndy, maj, mnr;
  logic                      dy_zero, dy_pos, use_err;

  always_comb begin
    swap = x_a_i > x_b_i;
    x0 = swap ? x_b_i : x_a_i;
    y0 = swap ? y_b_i : y_a_i;
    x1 = swap ? x_a_i : x_b_i;
    y1 = swap ? y_a_i : y_b_i;
    dx = $signed({3'b000, x1}) - $signed({3'b000, x0});
    dy = $signed({3'b000, y1}) - $signed({3'b000, y0});
    ndx = -dx;
    ndy = -dy;
    dy_zero = (dy == ndx + dx) && (dy[ErrBits-1:0] == {ErrBits{1'b0}});
    dy_pos = !dy[ErrBits-1] && !dy_zero;

    cur_x_o = x0;
    cur_y_o = y0;
    stop_o  = x1;
    maj = dx;
    mnr = dy;
    use_err = 1'b1;
    if (dy_zero) begin
      mode_o = brl_pkg::OCT_HORIZ;
      use_err = 1'b0;
    end else if (dx[ErrBits-1:0] == {ErrBits{1'b0}}) begin
      // Vertical lines always run toward larger y.
      mode_o = brl_pkg::OCT_VERT;
      cur_y_o = (y0 < y1) ? y0 : y1;
      stop_o  = (y0 < y1) ? y1 : y0;
      use_err = 1'b0;
    end else if (dy == dx) begin
      mode_o = brl_pkg::OCT_DIAG_RISE;
      use_err = 1'b0;
    end else if (dy == ndx) begin
      mode_o = brl_pkg::OCT_DIAG_FALL;
      use_err = 1'b0;
    end else if (dy_pos && (dy < dx)) begin
      mode_o = brl_pkg::OCT_SHAL_RISE;
    end else if (dy > dx) begin
      mode_o = brl_pkg::OCT_STEEP_RISE;
      maj = dy;
      mnr = dx;
      stop_o = y1;
    end else if (ndy < dx) begin
      mode_o = brl_pkg::OCT_SHAL_FALL;
      mnr = ndy;
    end else begin
      mode_o = brl_pkg::OCT_STEEP_FALL;
      maj = ndy;
      mnr = dx;
      stop_o = y1;
    end

    if (use_err) begin
      err_o         = (mnr <<< 1) - maj;
      inc_no_step_o = mnr <<< 1;
      inc_step_o    = (mnr <<< 1) - (maj <<< 1);
    end else begin
      err_o         = '0;
      inc_no_step_o = '0;
      inc_step_o    = '0;
    end
  end

endmodule

>>> hw/rtl/brl_step.sv
module brl_step #(
  parameter int unsigned CoordBits = 10
) (
  input  brl_pkg::octant_e       mode_i,
  input  logic [CoordBits-1:0]   cur_x_i,
  input  logic [CoordBits-1:0]   cur_y_i,
  input  logic [CoordBits-1:0]   stop_i,
  input  logic [CoordBits+2:0]   err_i,
  input  logic [CoordBits+2:0]   inc_no_step_i,
  input  logic [CoordBits+2:0]   inc_step_i,
  output logic [CoordBits-1:0]   nxt_x_o,
  output logic [CoordBits-1:0]   nxt_y_o,
  output logic [CoordBits+2:0]   nxt_err_o,
  output brl_pkg::step_flags_t   flags_o
);

  localparam logic [CoordBits-1:0] One = {{(CoordBits-1){1'b0}}, 1'b1};

  logic stepm, y_major, use_err;

  always_comb begin
    stepm = !err_i[CoordBits+2];
    y_major = (mode_i == brl_pkg::OCT_VERT) || (mode_i == brl_pkg::OCT_STEEP_RISE) ||
              (mode_i == brl_pkg::OCT_STEEP_FALL);
    use_err = (mode_i == brl_pkg::OCT_SHAL_RISE) || (mode_i == brl_pkg::OCT_SHAL_FALL) ||
              (mode_i == brl_pkg::OCT_STEEP_RISE) || (mode_i == brl_pkg::OCT_STEEP_FALL);

    flags_o.last = (y_major ? cur_y_i : cur_x_i) == stop_i;

    nxt_err_o = use_err ? (err_i + (stepm ? inc_step_i : inc_no_step_i)) : err_i;

    nxt_x_o = cur_x_i;
    nxt_y_o = cur_y_i;
    case (mode_i)
      brl_pkg::OCT_HORIZ: begin
        nxt_x_o = cur_x_i + One;
      end
      brl_pkg::OCT_VERT: begin
        nxt_y_o = cur_y_i + One;
      end
      brl_pkg::OCT_DIAG_RISE: begin
        nxt_x_o = cur_x_i + One;
        nxt_y_o = cur_y_i + One;
      end
      brl_pkg::OCT_DIAG_FALL: begin
        nxt_x_o = cur_x_i + One;
        nxt_y_o = cur_y_i - One;
      end
      brl_pkg::OCT_SHAL_RISE: begin
        nxt_x_o = cur_x_i + One;
        if (stepm) nxt_y_o = cur_y_i + One;
      end
      brl_pkg::OCT_STEEP_RISE: begin
        nxt_y_o = cur_y_i + One;
        if (stepm) nxt_x_o = cur_x_i + One;
      end
      brl_pkg::OCT_SHAL_FALL: begin
        nxt_x_o = cur_x_i + One;
        if (stepm) nxt_y_o = cur_y_i - One;
      end
      default: begin
        nxt_y_o = cur_y_i - One;
        if (stepm) nxt_x_o = cur_x_i + One;
      end
    endcase
  end

endmodule

>>> hw/rtl/bresenham_line_rasterizer.sv
// Bresenham line rasterizer. A load transaction (command 0) takes two endpoints and
// sets up the line without giving a result; each pixel transaction (command 1) gives
// one pixel with the configured color and advances the error term, and the final
// pixel carries last. A pixel transaction while no line is in progress gives nothing,
// and a load drops any line in progress. The block takes one transaction per clock:
// a transaction goes into an input register, is handled from there by the line
// setup or the step logic (one add and compare), and its pixel lands in the output
// register. Throughput is one transaction per cycle whenever the output side takes
// results; a stalled output holds the input register and then in_ready_o.
module bresenham_line_rasterizer #(
  parameter int unsigned CoordBits = 10
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [brl_pkg::ApbAddrBits-1:0]     paddr,
  input  logic [brl_pkg::ApbDataBits-1:0]     pwdata,
  output logic [brl_pkg::ApbDataBits-1:0]     prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                command_i,
  input  logic [CoordBits-1:0]                x_start_i,
  input  logic [CoordBits-1:0]                y_start_i,
  input  logic [CoordBits-1:0]                x_end_i,
  input  logic [CoordBits-1:0]                y_end_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [CoordBits-1:0]                pixel_x_o,
  output logic [CoordBits-1:0]                pixel_y_o,
  output logic [brl_pkg::ColorBits-1:0]       color_o,
  output logic                                last_o
);

  localparam int unsigned ErrBits = CoordBits + 3;

  // Configuration.
  logic [brl_pkg::ColorBits-1:0] color_q;
  logic                          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == brl_pkg::RegPixelColor);
  assign prdata = (paddr[2] == brl_pkg::RegPixelColor) ?
                  {{(brl_pkg::ApbDataBits-brl_pkg::ColorBits){1'b0}}, color_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_q <= brl_pkg::ColorReset;
    end else if (cfg_wr) begin
      color_q <= pwdata[brl_pkg::ColorBits-1:0];
    end
  end

  // Input register.
  logic                 in_valid_q;
  brl_pkg::cmd_e        cmd_q;
  logic [CoordBits-1:0] xs_q, ys_q, xe_q, ye_q;
  logic                 advance, fire, is_load, emit;
  logic                 busy_q;
  logic                 out_valid_q;

  always_comb begin
    advance    = !out_valid_q || out_ready_i;
    in_ready_o = !in_valid_q || advance;
    fire       = in_valid_q && advance;
    is_load    = cmd_q == brl_pkg::CMD_LOAD;
    emit       = fire && !is_load && busy_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= brl_pkg::cmd_e'(command_i);
      xs_q  <= x_start_i;
      ys_q  <= y_start_i;
      xe_q  <= x_end_i;
      ye_q  <= y_end_i;
    end
  end

  // Line state.
  logic [CoordBits-1:0] cur_x_q, cur_y_q, stop_q;
  logic [ErrBits-1:0]   err_q, inc_ns_q, inc_s_q;
  brl_pkg::octant_e     mode_q;

  logic [CoordBits-1:0] ld_x, ld_y, ld_stop, nxt_x, nxt_y;
  logic [ErrBits-1:0]   ld_err, ld_inc_ns, ld_inc_s, nxt_err;
  brl_pkg::octant_e     ld_mode;
  brl_pkg::step_flags_t flags;

  brl_setup #(.CoordBits(CoordBits)) u_setup (
    .x_a_i         (xs_q),
    .y_a_i         (ys_q),
    .x_b_i         (xe_q),
    .y_b_i         (ye_q),
    .cur_x_o       (ld_x),
    .cur_y_o       (ld_y),
    .stop_o        (ld_stop),
    .err_o         (ld_err),
    .inc_no_step_o (ld_inc_ns),
    .inc_step_o    (ld_inc_s),
    .mode_o        (ld_mode)
  );

  brl_step #(.CoordBits(CoordBits)) u_step (
    .mode_i        (mode_q),
    .cur_x_i       (cur_x_q),
    .cur_y_i       (cur_y_q),
    .stop_i        (stop_q),
    .err_i         (err_q),
    .inc_no_step_i (inc_ns_q),
    .inc_step_i    (inc_s_q),
    .nxt_x_o       (nxt_x),
    .nxt_y_o       (nxt_y),
    .nxt_err_o     (nxt_err),
    .flags_o       (flags)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cur_x_q  <= '0;
      cur_y_q  <= '0;
      stop_q   <= '0;
      err_q    <= '0;
      inc_ns_q <= '0;
      inc_s_q  <= '0;
      mode_q   <= brl_pkg::OCT_HORIZ;
    end else if (fire && is_load) begin
      busy_q   <= 1'b1;
      cur_x_q  <= ld_x;
      cur_y_q  <= ld_y;
      stop_q   <= ld_stop;
      err_q    <= ld_err;
      inc_ns_q <= ld_inc_ns;
      inc_s_q  <= ld_inc_s;
      mode_q   <= ld_mode;
    end else if (emit) begin
      if (flags.last) begin
        busy_q <= 1'b0;
      end else begin
        cur_x_q <= nxt_x;
        cur_y_q <= nxt_y;
        err_q   <= nxt_err;
      end
    end
  end

  // Output register.
  logic [CoordBits-1:0]          px_q, py_q;
  logic [brl_pkg::ColorBits-1:0] pcolor_q;
  logic                          last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      px_q     <= cur_x_q;
      py_q     <= cur_y_q;
      pcolor_q <= color_q;
      last_q   <= flags.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o   = px_q;
  assign pixel_y_o   = py_q;
  assign color_o     = pcolor_q;
  assign last_o      = last_q;

  // The final pixel of a line ends it.
  a_last_ends_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && flags.last |=> !busy_q)
    else $error("line still busy after its final pixel");

  // A blocked output freezes the line state.
  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(cur_x_q) && $stable(cur_y_q) && $stable(busy_q) &&
                 $stable(err_q))
    else $error("line state moved while the output was stalled");

  // Along an x-major line x never passes the stop coordinate.
  a_x_major_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (mode_q == brl_pkg::OCT_HORIZ || mode_q == brl_pkg::OCT_DIAG_RISE ||
               mode_q == brl_pkg::OCT_DIAG_FALL || mode_q == brl_pkg::OCT_SHAL_RISE ||
               mode_q == brl_pkg::OCT_SHAL_FALL) |-> cur_x_q <= stop_q)
    else $error("x passed the end of the line");

  // Along a vertical or steep rising line y moves toward the stop coordinate and never past it.
  a_y_major_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && (mode_q == brl_pkg::OCT_VERT || mode_q == brl_pkg::OCT_STEEP_RISE)
    |-> cur_y_q <= stop_q)
    else $error("y passed the end of a rising line");

endmodule
